[hdl/prr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prr_pkg
// Shared types and constants of the polyphase rational resampler.
// ----------------------------------------------------------------------------
package prr_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEF_AW  = 12;
   localparam int TAPCNT_W = 9;
   localparam int PHCNT_W  = 5;
   localparam int WHOLE_W  = 8;
   localparam int FRAC_W   = 4;
   localparam int SKIP_W   = 9;
   localparam int CHAN_W   = 3;
   localparam int ACC_W    = 48;
   localparam int RES_CAP  = 16;
   localparam int RND_SHIFT = 15;

   localparam logic [1:0] REG_TAP_COUNT   = 2'd0;
   localparam logic [1:0] REG_PHASE_COUNT = 2'd1;
   localparam logic [1:0] REG_STEP_WHOLE  = 2'd2;
   localparam logic [1:0] REG_STEP_FRAC   = 2'd3;

   localparam logic KIND_COEF   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sd32768;

   // Multiply-accumulate step handed down the cell row
   typedef struct packed {
      logic                       valid;
      logic                       first;
      logic                       final_tap;
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] c;
   } mac_op_type;

endpackage
`default_nettype wire

[hdl/prr_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module prr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[hdl/prr_mac_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prr_mac_cell
// One cell of the MAC row: it multiplies, or accumulates when is_adder is set.
// Each cell registers its work and hands it to the neighbor every cycle.
// ----------------------------------------------------------------------------
module prr_mac_cell (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               is_adder,
   input  wire prr_pkg::mac_op_type                op_in,
   input  wire logic signed [prr_pkg::ACC_W-1:0]   prod_in,
   output prr_pkg::mac_op_type                     op_out,
   output logic signed [prr_pkg::ACC_W-1:0]        data_out
);
   import prr_pkg::*;

   mac_op_type              op_ff;
   logic signed [ACC_W-1:0] data_ff, data_in;

   // Multiply in the first cell, accumulate in the second
   always_comb begin
      if (!is_adder) begin
         data_in = ACC_W'(op_in.x * op_in.c);
      end else if (op_in.first) begin
         data_in = prod_in;
      end else begin
         data_in = data_ff + prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff.valid <= 1'b0;
      end else begin
         op_ff.valid <= op_in.valid;
      end
      op_ff.first     <= op_in.first;
      op_ff.final_tap <= op_in.final_tap;
      op_ff.x         <= op_in.x;
      op_ff.c         <= op_in.c;
      if (op_in.valid) begin
         data_ff <= data_in;
      end
   end

   assign op_out   = op_ff;
   assign data_out = data_ff;
endmodule
`default_nettype wire

[hdl/polyphase_rational_resampler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// polyphase_rational_resampler
// Polyphase FIR rational resampler, direct coefficient table.
// ----------------------------------------------------------------------------
// One item at a time. A coefficient word is written straight into the table.
// A sample word first shifts its channel's history (a RAM ring, one pointer
// per channel), then for each output walks the taps through one shared
// multiply-accumulate row of two cells at one tap per cycle. A sample gives
// up to 16 outputs, and each output word waits for the sink while the output
// register is full. After reset a clearing pass zeroes all CHANNELS*MAX_TAPS
// history words; no word is taken meanwhile.
// Results leave through a one-word output register.
module polyphase_rational_resampler #(
   parameter int MAX_TAPS   = 256,
   parameter int CHANNELS   = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [2:0] chan, [14:3] coef_addr, [30:15] value, [31] zero fill
   input  wire logic [31:0] req_tdata,
   // [0] kind
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] sample_out, [18:16] out_chan, [23:19] zero fill
   output logic [23:0]      rsp_tdata,
   // [0] clipped
   output logic             rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_wdata
);
   import prr_pkg::*;

   localparam int TAP_AW = $clog2(MAX_TAPS);
   localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int HIST_D = CHANNELS * MAX_TAPS;
   localparam int HIST_AW = $clog2(HIST_D);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_TAPS  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_SEND  = 3'd4;

   // Field unpacking
   logic                       in_kind;
   logic [CHAN_W-1:0]          in_chan;
   logic [COEF_AW-1:0]         in_addr;
   logic signed [SAMPLE_W-1:0] in_value;
   assign in_kind  = req_tuser;
   assign in_chan  = req_tdata[2:0];
   assign in_addr  = req_tdata[14:3];
   assign in_value = req_tdata[30:15];

   // Configuration registers
   logic [TAPCNT_W-1:0] tap_count_ff;
   logic [PHCNT_W-1:0]  phase_count_ff;
   logic [WHOLE_W-1:0]  step_whole_ff;
   logic [FRAC_W-1:0]   step_frac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff   <= TAPCNT_W'(64);
         phase_count_ff <= PHCNT_W'(1);
         step_whole_ff  <= WHOLE_W'(1);
         step_frac_ff   <= FRAC_W'(0);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_TAP_COUNT:   tap_count_ff   <= csr_wdata;
            REG_PHASE_COUNT: phase_count_ff <= csr_wdata[PHCNT_W-1:0];
            REG_STEP_WHOLE:  step_whole_ff  <= csr_wdata[WHOLE_W-1:0];
            REG_STEP_FRAC:   step_frac_ff   <= csr_wdata[FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective tap count, saturated to MAX_TAPS
   logic [TAP_AW:0] taps_eff;
   assign taps_eff = (32'(tap_count_ff) > MAX_TAPS) ? (TAP_AW+1)'(MAX_TAPS)
                                                    : (TAP_AW+1)'(tap_count_ff);

   // Control state
   logic [2:0]            state_ff, state_in;
   logic [HIST_AW-1:0]    clr_ff;
   logic [CH_AW-1:0]      ch_ff;
   logic [TAP_AW-1:0]     head_ff [CHANNELS];
   logic [FRAC_W-1:0]     phase_ff [CHANNELS];
   logic [SKIP_W-1:0]     skip_ff [CHANNELS];
   logic [SKIP_W:0]       skip_w_ff;
   logic [FRAC_W:0]       ph_w_ff;
   logic [4:0]            nout_ff;
   logic [TAP_AW:0]       tap_ff;
   logic [COEF_AW-1:0]    caddr_ff;

   logic accept;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   logic sample_ok;
   assign sample_ok = (in_kind == KIND_SAMPLE) && (32'(in_chan) < CHANNELS);

   // History RAM: ring per channel, head points at newest sample
   logic                 hwr_en;
   logic [HIST_AW-1:0]   hwr_addr, hrd_addr;
   logic [SAMPLE_W-1:0]  hwr_data, hrd_data;
   logic [TAP_AW-1:0]    new_head;
   assign new_head = head_ff[CH_AW'(in_chan)] - TAP_AW'(1);

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         hwr_en   = 1'b1;
         hwr_addr = clr_ff;
         hwr_data = '0;
      end else begin
         hwr_en   = accept && sample_ok;
         hwr_addr = HIST_AW'({CH_AW'(in_chan), new_head});
         hwr_data = in_value;
      end
   end

   // Age N-1-j sits at head + N-1-j
   logic [TAP_AW-1:0] age;
   assign age = TAP_AW'(taps_eff - (TAP_AW+1)'(1) - tap_ff);
   assign hrd_addr = HIST_AW'({ch_ff, TAP_AW'(head_ff[ch_ff] + age)});

   prr_ram #(.WIDTH(SAMPLE_W), .DEPTH(HIST_D)) u_hist (
      .clock(clock), .wr_en(hwr_en), .wr_addr(hwr_addr), .wr_data(hwr_data),
      .rd_addr(hrd_addr), .rd_data(hrd_data)
   );

   logic [SAMPLE_W-1:0] crd_data;
   prr_ram #(.WIDTH(SAMPLE_W), .DEPTH(1 << COEF_AW)) u_coef (
      .clock(clock), .wr_en(accept && (in_kind == KIND_COEF)),
      .wr_addr(in_addr), .wr_data(in_value),
      .rd_addr(caddr_ff), .rd_data(crd_data)
   );

   // Issue stage: one tap read per cycle, op follows the RAM latency
   logic issue;
   logic issue_first, issue_final;
   assign issue       = (state_ff == ST_TAPS) && (tap_ff < taps_eff);
   assign issue_first = (tap_ff == '0);
   assign issue_final = (tap_ff == taps_eff - (TAP_AW+1)'(1));

   mac_op_type rd_op_ff, op0;
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_op_ff.valid <= 1'b0;
      end else begin
         rd_op_ff.valid <= issue;
      end
      rd_op_ff.first     <= issue_first;
      rd_op_ff.final_tap <= issue_final;
      rd_op_ff.x         <= '0;
      rd_op_ff.c         <= '0;
   end

   always_comb begin
      op0   = rd_op_ff;
      op0.x = hrd_data;
      op0.c = crd_data;
   end

   // Two-cell MAC row: multiply cell hands its product to the add cell
   mac_op_type              op1, op2;
   logic signed [ACC_W-1:0] prod, acc;
   prr_mac_cell u_mul (
      .clock(clock), .reset(reset), .is_adder(1'b0), .op_in(op0),
      .prod_in('0), .op_out(op1), .data_out(prod)
   );
   prr_mac_cell u_acc (
      .clock(clock), .reset(reset), .is_adder(1'b1), .op_in(op1),
      .prod_in(prod), .op_out(op2), .data_out(acc)
   );

   logic acc_done;
   assign acc_done = op2.valid && op2.final_tap;

   // Round, shift and saturate
   logic signed [ACC_W-1:0] sum, rnd;
   logic                    sum_zero_ff;
   assign sum = sum_zero_ff ? '0 : acc;
   assign rnd = (sum + ACC_W'(16384)) >>> RND_SHIFT;

   logic signed [SAMPLE_W-1:0] y;
   logic                       clip;
   always_comb begin
      clip = 1'b1;
      if (rnd > ACC_W'(SAT_MAX)) begin
         y = SAT_MAX;
      end else if (rnd < ACC_W'(SAT_MIN)) begin
         y = SAT_MIN;
      end else begin
         y    = SAMPLE_W'(rnd);
         clip = 1'b0;
      end
   end

   // Counter update after an output
   logic [SKIP_W:0] skip_nx;
   logic [FRAC_W:0] ph_sum;
   logic            wrap;
   logic [FRAC_W:0] ph_nx;
   assign ph_sum  = ph_w_ff + (FRAC_W+1)'(step_frac_ff);
   assign wrap    = ph_sum >= (FRAC_W+1)'(phase_count_ff);
   assign ph_nx   = wrap ? ph_sum - (FRAC_W+1)'(phase_count_ff) : ph_sum;
   assign skip_nx = skip_w_ff + (SKIP_W+1)'(step_whole_ff) + (SKIP_W+1)'(wrap);

   logic more;
   assign more = (skip_nx == '0) && (nout_ff != 5'(RES_CAP - 1));

   // Output register
   logic                       out_v_ff;
   logic signed [SAMPLE_W-1:0] out_y_ff;
   logic                       out_clip_ff, out_last_ff;
   logic [CHAN_W-1:0]          out_ch_ff;

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {5'd0, out_ch_ff, out_y_ff};
   assign rsp_tuser  = out_clip_ff;
   assign rsp_tlast  = out_last_ff;

   // Load a new word once the output register is free
   logic load_out;
   assign load_out = (state_ff == ST_SEND) && (!out_v_ff || rsp_tready);

   logic [COEF_AW-1:0] cbase;
   assign cbase = COEF_AW'(ph_nx[FRAC_W-1:0] * taps_eff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == HIST_AW'(HIST_D - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (accept && sample_ok && (skip_ff[CH_AW'(in_chan)] == '0)) begin
            state_in = ST_TAPS;
         end
         ST_TAPS:  if (tap_ff >= taps_eff) state_in = ST_DRAIN;
         ST_DRAIN: if (acc_done || sum_zero_ff) state_in = ST_SEND;
         ST_SEND:  if (load_out) state_in = more ? ST_TAPS : ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            head_ff[i]  <= '0;
            phase_ff[i] <= '0;
            skip_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         // Set on a new word, drop once taken
         if (load_out) begin
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: clr_ff <= clr_ff + HIST_AW'(1);
            ST_IDLE: if (accept && sample_ok) begin
               ch_ff     <= CH_AW'(in_chan);
               head_ff[CH_AW'(in_chan)] <= new_head;
               if (skip_ff[CH_AW'(in_chan)] != '0) begin
                  skip_ff[CH_AW'(in_chan)] <= skip_ff[CH_AW'(in_chan)] - SKIP_W'(1);
               end
               skip_w_ff    <= '0;
               ph_w_ff      <= (FRAC_W+1)'(phase_ff[CH_AW'(in_chan)]);
               nout_ff      <= '0;
               tap_ff       <= '0;
               sum_zero_ff  <= (taps_eff == '0);
               caddr_ff     <= COEF_AW'(phase_ff[CH_AW'(in_chan)] * taps_eff);
            end
            ST_TAPS: if (issue) begin
               tap_ff   <= tap_ff + (TAP_AW+1)'(1);
               caddr_ff <= caddr_ff + COEF_AW'(1);
            end
            ST_SEND: if (load_out) begin
               out_y_ff    <= y;
               out_clip_ff <= clip;
               out_ch_ff   <= CHAN_W'(ch_ff);
               out_last_ff <= !more;
               nout_ff     <= nout_ff + 5'(1);
               skip_w_ff   <= skip_nx;
               ph_w_ff     <= {1'b0, ph_nx[FRAC_W-1:0]};
               tap_ff      <= '0;
               caddr_ff    <= cbase;
               if (!more) begin
                  phase_ff[ch_ff] <= ph_nx[FRAC_W-1:0];
                  skip_ff[ch_ff]  <= (skip_nx == '0) ? '0
                                     : SKIP_W'(skip_nx - (SKIP_W+1)'(1));
               end
            end
            default: ;
         endcase
      end
   end

   // Checks
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("input taken while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_tready) |=> (out_v_ff && $stable(out_y_ff)))
      else $error("output word lost");
   a_final_in_range: assert property (@(posedge clock) disable iff (reset)
      acc_done |-> (state_ff == ST_DRAIN || state_ff == ST_TAPS))
      else $error("MAC result outside tap walk");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> (nout_ff < 5'(RES_CAP)))
      else $error("too many outputs per sample");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !out_last_ff) |-> (state_ff != ST_IDLE))
      else $error("walk ended before last word");
endmodule
`default_nettype wire

[tb/tb_polyphase_rational_resampler.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polyphase_rational_resampler
// Self-checking bench for the polyphase rational resampler.
// ----------------------------------------------------------------------------
// A queue of pending words feeds a clocked driver. Each word taken by the
// block is run through a local resampler predictor that keeps its own
// coefficient table, per-channel tap history, phase and skip counters. A
// monitor compares every output word with the oldest predicted one. The run
// steps through several register settings, always with the block idle.
// Only the low part of the coefficient table is filled, so every setting
// keeps phase times tap count plus tap inside it.
// ----------------------------------------------------------------------------
module tb_polyphase_rational_resampler;
   import prr_pkg::*;

   localparam int TAP_CAP      = 256;
   localparam int CHAN_NUM     = 8;
   localparam int TABLE_DEPTH  = 4096;
   localparam int FILL_DEPTH   = 128;
   localparam int SETTLE_CYC   = 300;
   localparam int STALL_LIMIT  = 20000;

   typedef struct {
      logic                       kind;
      logic [CHAN_W-1:0]          chan;
      logic [COEF_AW-1:0]         addr;
      logic signed [SAMPLE_W-1:0] value;
   } in_word_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic [CHAN_W-1:0]          chan;
      logic                       last;
      logic                       clipped;
   } out_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [8:0]  csr_wdata = '0;

   // Predictor state
   logic signed [SAMPLE_W-1:0] coef_mem [TABLE_DEPTH];
   logic signed [SAMPLE_W-1:0] history [CHAN_NUM][TAP_CAP];
   int unsigned                phase_st [CHAN_NUM];
   int unsigned                skip_st [CHAN_NUM];
   int unsigned                cfg_taps, cfg_phases, cfg_whole, cfg_frac;

   in_word_type  pending_q [$];
   out_word_type resample_q [$];

   bit calm;
   bit req_fired;
   int req_gap, rsp_gap;
   int mismatch_count;
   int stall_cycles;

   polyphase_rational_resampler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Compute the outputs that one taken word causes
   task automatic resample_predict(input in_word_type w);
      int unsigned skip, ph, taps, outs;
      longint acc, r;
      out_word_type o;
      if (w.kind == KIND_COEF) begin
         coef_mem[w.addr] = w.value;
         return;
      end
      for (int k = TAP_CAP - 1; k > 0; k--) history[w.chan][k] = history[w.chan][k-1];
      history[w.chan][0] = w.value;
      skip = skip_st[w.chan];
      ph   = phase_st[w.chan];
      outs = 0;
      taps = (cfg_taps > TAP_CAP) ? TAP_CAP : cfg_taps;
      while (skip == 0 && outs < RES_CAP) begin
         acc = 0;
         for (int j = 0; j < taps; j++)
            acc += longint'(history[w.chan][taps-1-j]) *
                   longint'(coef_mem[(ph * taps + j) % TABLE_DEPTH]);
         r = (acc + 16384) >>> RND_SHIFT;
         o.clipped = 1'b0;
         if (r > 32767) begin
            r = 32767;
            o.clipped = 1'b1;
         end
         if (r < -32768) begin
            r = -32768;
            o.clipped = 1'b1;
         end
         o.sample = r[15:0];
         o.chan   = w.chan;
         o.last   = 1'b0;
         resample_q.push_back(o);
         outs++;
         skip += cfg_whole;
         ph   += cfg_frac;
         if (ph >= cfg_phases) begin
            ph -= cfg_phases;
            skip++;
         end
         ph &= 15;
      end
      if (skip > 0) skip--;
      skip_st[w.chan]  = skip & 511;
      phase_st[w.chan] = ph;
      if (outs > 0) resample_q[resample_q.size()-1].last = 1'b1;
   endtask

   // Sample handshakes, predict, check, and watch for a hang
   always @(posedge clock) begin
      out_word_type e;
      if (!reset) begin
         stall_cycles++;
         if (req_tvalid && req_tready) begin
            resample_predict(pending_q.pop_front());
            req_fired = 1'b1;
            stall_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            stall_cycles = 0;
            if (resample_q.size() == 0) begin
               $error("unexpected output word: sample_out %0d", $signed(rsp_tdata[15:0]));
               mismatch_count++;
            end else begin
               e = resample_q.pop_front();
               if (rsp_tdata[15:0] !== e.sample) begin
                  $error("sample_out expected %0d got %0d", e.sample,
                         $signed(rsp_tdata[15:0]));
                  mismatch_count++;
               end
               if (rsp_tdata[18:16] !== e.chan) begin
                  $error("out_chan expected %0d got %0d", e.chan, rsp_tdata[18:16]);
                  mismatch_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last expected %0d got %0d", e.last, rsp_tlast);
                  mismatch_count++;
               end
               if (rsp_tuser !== e.clipped) begin
                  $error("clipped expected %0d got %0d", e.clipped, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[polyphase_rational_resampler] ERROR");
            $finish;
         end
      end
   end

   // Drive words and output backpressure at the falling edge
   always @(negedge clock) begin
      if (!req_tvalid || req_fired) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(0, 6);
            req_tvalid <= 1'b0;
         end else if (pending_q.size() > 0 && !reset) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {1'b0, pending_q[0].value, pending_q[0].addr, pending_q[0].chan};
            req_tuser  <= pending_q[0].kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_fired = 1'b0;
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic add_word(input logic kind, input int chan, input int addr, input int value);
      in_word_type w;
      w.kind  = kind;
      w.chan  = CHAN_W'(chan);
      w.addr  = COEF_AW'(addr);
      w.value = SAMPLE_W'(value);
      pending_q.push_back(w);
   endtask

   // Hold until every word is taken and every output checked, then settle
   task automatic drain();
      while (pending_q.size() != 0 || resample_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int unsigned val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 9'(val);
   endtask

   // Write all four registers while the block is idle
   task automatic set_config(input int unsigned taps, input int unsigned phases,
                             input int unsigned whole, input int unsigned frac);
      write_reg(REG_TAP_COUNT, taps);
      write_reg(REG_PHASE_COUNT, phases);
      write_reg(REG_STEP_WHOLE, whole);
      write_reg(REG_STEP_FRAC, frac);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cfg_taps   = taps;
      cfg_phases = phases;
      cfg_whole  = whole;
      cfg_frac   = frac;
   endtask

   // Mostly samples with random content, some coefficient rewrites
   task automatic add_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0)
            add_word(KIND_COEF, $urandom_range(0, 7), $urandom_range(0, 4095),
                     $urandom_range(0, 65535));
         else
            add_word(KIND_SAMPLE, $urandom_range(0, 7), $urandom_range(0, 4095),
                     $urandom_range(0, 65535));
      end
   endtask

   initial begin
      int unsigned ph;
      for (int c = 0; c < CHAN_NUM; c++) begin
         phase_st[c] = 0;
         skip_st[c]  = 0;
         for (int k = 0; k < TAP_CAP; k++) history[c][k] = '0;
      end
      cfg_taps   = 64;
      cfg_phases = 1;
      cfg_whole  = 1;
      cfg_frac   = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the low table; phase 15 times 8 taps plus 7 stays inside it
      for (int a = 0; a < FILL_DEPTH; a++)
         add_word(KIND_COEF, $urandom_range(0, 7), a, $urandom_range(0, 65535) >> 3);

      // Reset settings: phases stay zero, field extremes
      add_word(KIND_COEF, 7, 4095, -32768);
      add_word(KIND_COEF, 0, 0, 32767);
      add_word(KIND_SAMPLE, 0, 0, 32767);
      add_word(KIND_SAMPLE, 7, 4095, -32768);
      add_word(KIND_SAMPLE, 7, 0, 0);
      add_word(KIND_SAMPLE, 0, 4095, -1);
      drain();

      // Saturation in both directions with four full-scale taps
      set_config(4, 1, 1, 0);
      for (int a = 0; a < 4; a++) add_word(KIND_COEF, 0, a, 32767);
      for (int i = 0; i < 4; i++) add_word(KIND_SAMPLE, 1, 0, 32767);
      for (int i = 0; i < 4; i++) add_word(KIND_SAMPLE, 1, 0, -32768);
      add_word(KIND_COEF, 0, 2, -32768);
      add_word(KIND_SAMPLE, 1, 0, -32768);
      drain();

      // Zero taps, phase count of zero, runaway step, odd ratios
      set_config(0, 3, 1, 2);
      add_random(4);
      drain();
      set_config(8, 16, 0, 15);
      add_random(4);
      drain();
      set_config(3, 0, 0, 0);
      add_random(5);
      drain();
      set_config(5, 1, 0, 0);
      add_random(3);
      drain();
      set_config(8, 31, 255, 0);
      add_random(8);
      drain();
      set_config(8, 5, 1, 3);
      add_random(10);
      drain();
      set_config(7, 3, 0, 2);
      add_random(8);
      drain();
      set_config(8, 4, 2, 1);
      add_random(10);
      drain();

      // Random settings, the last stretch without idling
      for (int p = 0; p < 4; p++) begin
         ph = $urandom_range(1, 16);
         set_config($urandom_range(4, 8), ph, $urandom_range(0, 3), $urandom_range(0, ph - 1));
         if (p == 3) calm = 1'b1;
         add_random(5);
         drain();
      end

      if (mismatch_count == 0)
         $display("[polyphase_rational_resampler] OK");
      else
         $display("[polyphase_rational_resampler] ERROR");
      $finish;
   end

endmodule
